// ===== sv/color_ramp_lut_generator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Color ramp LUT generator assertion macros
// Shared property forms for the checker; clock and reset come from the scope.
// ----------------------------------------------------------------------------
`ifndef COLOR_RAMP_LUT_GENERATOR_CORE_ASSERT_SVH
`define COLOR_RAMP_LUT_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define CRLG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crlg assertion failed");

// next-cycle implication
`define CRLG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crlg assertion failed");

`endif

// ===== sv/crlg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp LUT generator package
// Beat types, table geometry, control codes and the entry-to-position table.
// ----------------------------------------------------------------------------
package crlg_pkg;

  localparam int MAX_STOPS = 16;
  localparam int LUT_WIDTH = 256;

  localparam int ADDR_W    = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CNT_W     = $clog2(MAX_STOPS + 1);
  localparam int LUT_IDX_W = (LUT_WIDTH > 1) ? $clog2(LUT_WIDTH) : 1;

  localparam int CFG_W     = 5;
  localparam int POS_W     = 16;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int POS_MAX   = (1 << POS_W) - 1;

  localparam int NUM_W     = 35;
  localparam int DEN_W     = POS_W + 1;
  localparam int DIV_STEPS = POS_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int CH_RED    = 0;
  localparam int CH_GREEN  = 1;
  localparam int CH_BLUE   = 2;
  localparam int CH_ALPHA  = 3;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [3:0]       stop_slot;
    logic [POS_W-1:0] stop_position;
    logic [CH_W-1:0]  stop_red;
    logic [CH_W-1:0]  stop_green;
    logic [CH_W-1:0]  stop_blue;
    logic [CH_W-1:0]  stop_alpha;
    logic [7:0]       entry_index;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            ramp_empty;
  } out_beat_t;

  typedef struct packed {
    logic [POS_W-1:0]             pos;
    logic [NUM_CH-1:0][CH_W-1:0]  ch;
  } stop_t;

  typedef enum logic [1:0] {
    RES_EMPTY,
    RES_LAST,
    RES_BLEND
  } res_sel_e;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              lat_query;
    logic              shift;
    logic              cap_lo;
    logic              cap_hi;
    logic              mul;
    logic              sum;
    logic              step;
    logic              out_load;
    res_sel_e          out_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;
    logic above;
  } dp_sts_t;

  typedef logic [POS_W-1:0] t16_lut_t [LUT_WIDTH];

  function automatic t16_lut_t build_t16_lut();
    t16_lut_t lut;
    for (int i = 0; i < LUT_WIDTH; i++) begin
      lut[i] = POS_W'((i * POS_MAX + (LUT_WIDTH - 1) / 2) / (LUT_WIDTH - 1));
    end
    return lut;
  endfunction

  localparam t16_lut_t T16_LUT = build_t16_lut();

endpackage

// ===== sv/color_ramp_lut_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp LUT generator core
// Piecewise linear RGBA color ramp, one colormap entry per query beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): a load beat writes one
// stop into the 16-entry stop table and gives no result; a query beat asks for
// one colormap entry and gives exactly one result beat on the output channel
// (out_valid_o / out_stall_i / out_data_o).
// cfg_we_i / cfg_wdata_i set the stop count; write it only while idle.
// A load is written into the table as it is accepted. A query on two or
// more stops scans the table one interval per cycle through the single
// table read port; a blended color then runs four 16-step restoring
// dividers in parallel, one per channel. An empty ramp goes straight to
// the result, while a single stop and the last-stop color are read back
// from the table. Input stays stalled while a query is in flight; the
// stall drops in the same cycle that result valid rises.
// The result sits in an output register: a load may be taken while it waits,
// and a finished query holds until the receiver drops out_stall_i.
// Reset clears the control state and the stop count; the stop table is not
// cleared and must be loaded before it is queried.
// ----------------------------------------------------------------------------
module color_ramp_lut_generator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  crlg_pkg::in_beat_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output crlg_pkg::out_beat_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [crlg_pkg::CFG_W-1:0] cfg_wdata_i
);
  import crlg_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  crlg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  crlg_dp u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== sv/crlg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp LUT generator controller
// Input handshake, stop count register, scan sequencing and result handoff.
// ----------------------------------------------------------------------------
module crlg_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  crlg_pkg::in_beat_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic                       cfg_we_i,
  input  logic [crlg_pkg::CFG_W-1:0] cfg_wdata_i,
  input  crlg_pkg::dp_sts_t          sts_i,
  output crlg_pkg::ctl_cmd_t         cmd_o
);
  import crlg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PRIME  = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_RD_LO  = 4'd3;
  localparam logic [3:0] S_CAP_LO = 4'd4;
  localparam logic [3:0] S_CAP_HI = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]           state_q, state_d;
  logic [ADDR_W-1:0]    ptr_q, ptr_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic [ADDR_W-1:0]    idx_n;
  logic                 last_q, last_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  res_sel_e             sel_q, sel_d;
  logic                 out_valid_q, out_valid_d;
  logic [CFG_W-1:0]     count_q;
  logic [CNT_W-1:0]     n;
  logic                 out_free;

  assign n          = (int'(count_q) > MAX_STOPS) ? CNT_W'(MAX_STOPS) : CNT_W'(count_q);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    idx_n     = idx_q;
    last_d    = last_q;
    div_cnt_d = div_cnt_q;
    sel_d     = sel_q;
    cmd_o         = '0;
    cmd_o.out_sel = sel_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.cmd == CMD_LOAD) begin
            cmd_o.wr_en = (int'(in_data_i.stop_slot) < MAX_STOPS);
          end else begin
            cmd_o.lat_query = 1'b1;
            if (n == '0) begin
              sel_d   = RES_EMPTY;
              state_d = S_DONE;
            end else if (n == CNT_W'(1)) begin
              idx_d   = '0;
              last_d  = 1'b1;
              state_d = S_RD_LO;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = '0;
              idx_d         = '0;
              state_d       = S_PRIME;
            end
          end
        end
      end
      S_PRIME: begin
        cmd_o.shift   = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = ADDR_W'(1);
        ptr_d         = ADDR_W'(1);
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          idx_n = ptr_q - ADDR_W'(1);
        end else if (sts_i.above) begin
          idx_n = ptr_q;
        end
        idx_d = idx_n;
        if (sts_i.hit || (CNT_W'(ptr_q) == n - CNT_W'(1))) begin
          last_d  = (CNT_W'(idx_n) >= n - CNT_W'(1));
          state_d = S_RD_LO;
        end else begin
          cmd_o.shift   = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ptr_q + ADDR_W'(1);
          ptr_d         = ptr_q + ADDR_W'(1);
        end
      end
      S_RD_LO: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q;
        state_d       = S_CAP_LO;
      end
      S_CAP_LO: begin
        cmd_o.cap_lo = 1'b1;
        if (last_q) begin
          sel_d   = RES_LAST;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_q + ADDR_W'(1);
          state_d       = S_CAP_HI;
        end
      end
      S_CAP_HI: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        div_cnt_d  = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          sel_d   = RES_BLEND;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      div_cnt_q   <= '0;
      sel_q       <= RES_EMPTY;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      div_cnt_q   <= div_cnt_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== sv/crlg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp LUT generator datapath
// Stop table, interval compare, per-channel products and restoring dividers.
// ----------------------------------------------------------------------------
module crlg_dp (
  input  logic                clk_i,
  input  crlg_pkg::in_beat_t  in_data_i,
  input  crlg_pkg::ctl_cmd_t  cmd_i,
  output crlg_pkg::dp_sts_t   sts_o,
  output crlg_pkg::out_beat_t out_data_o
);
  import crlg_pkg::*;

  stop_t                  mem [MAX_STOPS];
  stop_t                  rd_q;
  stop_t                  lo_q;
  stop_t                  hi_q;
  stop_t                  wr_stop;
  logic [POS_W-1:0]       t16_q;
  logic [POS_W-1:0]       prev_pos_q;
  logic [LUT_IDX_W-1:0]   t_idx;

  logic signed [DEN_W-1:0] d_s;
  logic signed [DEN_W-1:0] e_s;
  logic                    wz;
  logic [POS_W-1:0]        d16_q;
  logic                    wz_q;
  logic [DEN_W-1:0]        d2;

  logic [31:0]             p0_q    [NUM_CH];
  logic signed [33:0]      p1_q    [NUM_CH];
  logic [DEN_W-1:0]        rem_q   [NUM_CH];
  logic [POS_W-1:0]        low_q   [NUM_CH];
  logic [POS_W-1:0]        quo_q   [NUM_CH];
  logic                    sat_q   [NUM_CH];
  logic                    forced_q[NUM_CH];
  logic [CH_W-1:0]         fval_q  [NUM_CH];
  logic [CH_W-1:0]         lane_val[NUM_CH];
  out_beat_t               out_q;
  out_beat_t               out_d;

  assign t_idx = ({1'b0, in_data_i.entry_index} > 9'(LUT_WIDTH - 1)) ?
                 LUT_IDX_W'(LUT_WIDTH - 1) : LUT_IDX_W'(in_data_i.entry_index);

  always_comb begin
    wr_stop.pos          = in_data_i.stop_position;
    wr_stop.ch[CH_RED]   = in_data_i.stop_red;
    wr_stop.ch[CH_GREEN] = in_data_i.stop_green;
    wr_stop.ch[CH_BLUE]  = in_data_i.stop_blue;
    wr_stop.ch[CH_ALPHA] = in_data_i.stop_alpha;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[ADDR_W'(in_data_i.stop_slot)] <= wr_stop;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_query) begin
      t16_q <= T16_LUT[t_idx];
    end
    if (cmd_i.shift) begin
      prev_pos_q <= rd_q.pos;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rd_q;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= rd_q;
    end
  end

  assign sts_o.hit   = (t16_q >= prev_pos_q) && (t16_q <= rd_q.pos);
  assign sts_o.above = (t16_q > rd_q.pos);

  assign d_s = $signed({1'b0, hi_q.pos}) - $signed({1'b0, lo_q.pos});
  assign e_s = $signed({1'b0, t16_q}) - $signed({1'b0, lo_q.pos});
  assign wz  = (d_s <= 0) || (e_s <= 0);
  assign d2  = {d16_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      d16_q <= d_s[POS_W-1:0];
      wz_q  <= wz;
    end
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    logic [POS_W-1:0]        c0w;
    logic signed [CH_W:0]    diff;
    logic signed [DEN_W-1:0] diff257;
    logic signed [NUM_W-1:0] x;
    logic [NUM_W-1:0]        num;
    logic [DEN_W:0]          r;
    logic                    ge;

    assign c0w     = {lo_q.ch[k], lo_q.ch[k]};
    assign diff    = $signed({1'b0, hi_q.ch[k]}) - $signed({1'b0, lo_q.ch[k]});
    assign diff257 = $signed({diff, 8'b0}) + $signed({{8{diff[CH_W]}}, diff});
    assign x       = $signed({3'b0, p0_q[k]}) + NUM_W'(p1_q[k]);
    assign num     = {x[NUM_W-2:0], 1'b0} + NUM_W'(d16_q);
    assign r       = {rem_q[k], low_q[k][POS_W-1]};
    assign ge      = (r >= {1'b0, d2});

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul) begin
        p0_q[k] <= 32'(c0w) * 32'(d_s[POS_W-1:0]);
        p1_q[k] <= 34'(e_s) * 34'(diff257);
      end
      if (cmd_i.sum) begin
        rem_q[k]    <= num[POS_W+DEN_W-1:POS_W];
        low_q[k]    <= num[POS_W-1:0];
        quo_q[k]    <= '0;
        sat_q[k]    <= (num >= {2'b0, d2, {POS_W{1'b0}}});
        forced_q[k] <= wz_q || x[NUM_W-1];
        fval_q[k]   <= wz_q ? lo_q.ch[k] : '0;
      end
      if (cmd_i.step) begin
        rem_q[k] <= ge ? DEN_W'(r - {1'b0, d2}) : r[DEN_W-1:0];
        low_q[k] <= {low_q[k][POS_W-2:0], 1'b0};
        quo_q[k] <= {quo_q[k][POS_W-2:0], ge};
      end
    end

    assign lane_val[k] = forced_q[k] ? fval_q[k] :
                         sat_q[k]    ? {CH_W{1'b1}} : quo_q[k][POS_W-1:POS_W-CH_W];
  end

  always_comb begin
    out_d = '0;
    case (cmd_i.out_sel)
      RES_EMPTY: begin
        out_d.ramp_empty = 1'b1;
      end
      RES_LAST: begin
        out_d.out_red   = lo_q.ch[CH_RED];
        out_d.out_green = lo_q.ch[CH_GREEN];
        out_d.out_blue  = lo_q.ch[CH_BLUE];
        out_d.out_alpha = lo_q.ch[CH_ALPHA];
      end
      RES_BLEND: begin
        out_d.out_red   = lane_val[CH_RED];
        out_d.out_green = lane_val[CH_GREEN];
        out_d.out_blue  = lane_val[CH_BLUE];
        out_d.out_alpha = lane_val[CH_ALPHA];
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== sv/crlg_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp LUT generator port checker
// Watches the top-level channels over time; bound to the core below.
// ----------------------------------------------------------------------------
`include "color_ramp_lut_generator_core_assert.svh"

module crlg_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input crlg_pkg::in_beat_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input crlg_pkg::out_beat_t out_data_o
);
  import crlg_pkg::*;

  logic query_beat;
  logic out_black;

  assign query_beat = in_valid_i && !in_stall_o && (in_data_i.cmd == CMD_QUERY);
  assign out_black  = (out_data_o.out_red == '0) && (out_data_o.out_green == '0) &&
                      (out_data_o.out_blue == '0) && (out_data_o.out_alpha == '0);

  `CRLG_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `CRLG_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o))
  `CRLG_ASSERT_IMP(a_empty_black, out_valid_o && out_data_o.ramp_empty, out_black)
  `CRLG_ASSERT_NXT(a_query_busy, query_beat, in_stall_o)

endmodule

bind color_ramp_lut_generator_core crlg_chk u_crlg_chk (.*);

// ===== tb/tb_color_ramp_lut_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp LUT generator core testbench
// Loads color stops, sets the stop count and queries colormap entries through
// the valid/stall channels with random idle bursts on both sides. A bit-exact
// fixed-point model of the ramp predicts every result beat the plan does not
// give outright; each beat is compared field by field as it leaves the core.
// ----------------------------------------------------------------------------
module tb_color_ramp_lut_generator_core;
  import crlg_pkg::*;

  typedef enum logic [1:0] {OP_LOAD, OP_QUERY, OP_SET_COUNT} plan_op_e;

  typedef struct packed {
    plan_op_e    op;
    logic [3:0]  slot;
    logic [15:0] pos;
    logic [31:0] rgba;
    logic [7:0]  arg;
    logic        known;
    out_beat_t   want;
  } plan_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_beat_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_beat_t  out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  logic [15:0] stop_pos [MAX_STOPS];
  logic [7:0]  stop_rgba [MAX_STOPS][NUM_CH];
  logic [CFG_W-1:0] active_stops = '0;
  out_beat_t   pending_colors [$];
  out_beat_t   due;
  plan_row_t   opening_plan [$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          gap_pct = 30;
  int          stall_pct = 30;

  color_ramp_lut_generator_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] mix_channel(input longint c0, input longint c1,
                                             input longint e, input longint d);
    longint x;
    longint v;
    if (d <= 0 || e <= 0) return c0[7:0];
    x = c0 * 257 * d + e * (c1 - c0) * 257;
    if (x < 0) return 8'd0;
    v = (2 * x + d) / (2 * d);
    if (v > 65535) v = 65535;
    return v[15:8];
  endfunction

  function automatic out_beat_t ramp_color(input logic [7:0] entry);
    int n;
    int lo;
    bit found;
    longint t16;
    longint d;
    longint e;
    logic [7:0] col [NUM_CH];
    out_beat_t r;
    n = (active_stops > MAX_STOPS) ? MAX_STOPS : int'(active_stops);
    // entry/255 in the 16-bit position scale
    t16 = longint'(entry) * 257;
    r = '0;
    for (int k = 0; k < NUM_CH; k++) col[k] = 8'd0;
    if (n == 0) begin
      r.ramp_empty = 1'b1;
    end else if (n == 1) begin
      for (int k = 0; k < NUM_CH; k++) col[k] = stop_rgba[0][k];
    end else begin
      lo = 0;
      found = 1'b0;
      for (int j = 0; j + 1 < n; j++) begin
        if (!found) begin
          if (t16 >= longint'(stop_pos[j]) && t16 <= longint'(stop_pos[j + 1])) begin
            lo = j;
            found = 1'b1;
          end else if (t16 > longint'(stop_pos[j + 1])) begin
            lo = j + 1;
          end
        end
      end
      if (lo >= n - 1) begin
        for (int k = 0; k < NUM_CH; k++) col[k] = stop_rgba[n - 1][k];
      end else begin
        d = longint'(stop_pos[lo + 1]) - longint'(stop_pos[lo]);
        e = t16 - longint'(stop_pos[lo]);
        for (int k = 0; k < NUM_CH; k++)
          col[k] = mix_channel(stop_rgba[lo][k], stop_rgba[lo + 1][k], e, d);
      end
    end
    r.out_red   = col[CH_RED];
    r.out_green = col[CH_GREEN];
    r.out_blue  = col[CH_BLUE];
    r.out_alpha = col[CH_ALPHA];
    return r;
  endfunction

  function automatic plan_row_t plan_row(input plan_op_e op, input logic [3:0] slot,
                                         input logic [15:0] pos, input logic [31:0] rgba,
                                         input logic [7:0] arg, input logic known,
                                         input out_beat_t want);
    plan_row_t p;
    p.op    = op;
    p.slot  = slot;
    p.pos   = pos;
    p.rgba  = rgba;
    p.arg   = arg;
    p.known = known;
    p.want  = want;
    return p;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_beat(input in_beat_t b, input logic known, input out_beat_t want);
    int gap;
    gap = (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (b.cmd == CMD_LOAD) begin
      stop_pos[b.stop_slot]            = b.stop_position;
      stop_rgba[b.stop_slot][CH_RED]   = b.stop_red;
      stop_rgba[b.stop_slot][CH_GREEN] = b.stop_green;
      stop_rgba[b.stop_slot][CH_BLUE]  = b.stop_blue;
      stop_rgba[b.stop_slot][CH_ALPHA] = b.stop_alpha;
    end else begin
      pending_colors.push_back(known ? want : ramp_color(b.entry_index));
    end
  endtask

  task automatic set_stop_count(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    // let a trailing load settle
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    active_stops = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_colors.size() == 0) begin
        flag_mismatch("result beat with no query pending");
      end else begin
        due = pending_colors.pop_front();
        if (out_data_o.out_red !== due.out_red)
          flag_mismatch($sformatf("red got %h want %h", out_data_o.out_red, due.out_red));
        if (out_data_o.out_green !== due.out_green)
          flag_mismatch($sformatf("green got %h want %h",
                                  out_data_o.out_green, due.out_green));
        if (out_data_o.out_blue !== due.out_blue)
          flag_mismatch($sformatf("blue got %h want %h", out_data_o.out_blue, due.out_blue));
        if (out_data_o.out_alpha !== due.out_alpha)
          flag_mismatch($sformatf("alpha got %h want %h",
                                  out_data_o.out_alpha, due.out_alpha));
        if (out_data_o.ramp_empty !== due.ramp_empty)
          flag_mismatch($sformatf("empty got %b want %b",
                                  out_data_o.ramp_empty, due.ramp_empty));
      end
    end
  end

  initial begin
    int run;
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        run = $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (run) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("[color_ramp_lut_generator_core] ERROR");
    $finish;
  end

  initial begin
    in_beat_t b;
    logic [63:0] noise;
    logic [CFG_W-1:0] cnt;
    logic [15:0] pos_set [MAX_STOPS];
    logic [15:0] tmp;
    int phase;
    int n;
    int nq;
    int style;
    int m;

    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd0, 1'b1, {32'h0, 1'b1}));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd255, 1'b1, {32'h0, 1'b1}));
    opening_plan.push_back(plan_row(OP_LOAD, 4'd0, 16'h0000, 32'h00FF00FF, 0, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_SET_COUNT, 0, 0, 0, 8'd1, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd0, 1'b1, {32'h00FF00FF, 1'b0}));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd200, 1'b1, {32'h00FF00FF, 1'b0}));
    opening_plan.push_back(plan_row(OP_LOAD, 4'd1, 16'hFFFF, 32'hFF00FF00, 0, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_SET_COUNT, 0, 0, 0, 8'd2, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd0, 1'b1, {32'h00FF00FF, 1'b0}));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd255, 1'b1, {32'hFF00FF00, 1'b0}));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd128, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd77, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_LOAD, 4'd0, 16'h4000, 32'h12345678, 0, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_LOAD, 4'd1, 16'hC000, 32'h9ABCDEF0, 0, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd0, 1'b1, {32'h12345678, 1'b0}));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd255, 1'b1, {32'h9ABCDEF0, 1'b0}));
    opening_plan.push_back(plan_row(OP_LOAD, 4'd0, 16'h8080, 32'h12345678, 0, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_LOAD, 4'd1, 16'h8080, 32'h9ABCDEF0, 0, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd128, 1'b1, {32'h12345678, 1'b0}));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd129, 1'b1, {32'h9ABCDEF0, 1'b0}));
    opening_plan.push_back(plan_row(OP_LOAD, 4'd2, 16'hFFFF, 32'hFFFFFFFF, 0, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_SET_COUNT, 0, 0, 0, 8'd3, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd200, 1'b0, '0));
    opening_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 8'd10, 1'b1, {32'h12345678, 1'b0}));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_plan[r]) begin
      if (opening_plan[r].op == OP_SET_COUNT) begin
        set_stop_count(opening_plan[r].arg[CFG_W-1:0]);
      end else begin
        noise = {$urandom, $urandom};
        b = noise[$bits(in_beat_t)-1:0];
        if (opening_plan[r].op == OP_LOAD) begin
          b.cmd = CMD_LOAD;
          b.stop_slot = opening_plan[r].slot;
          b.stop_position = opening_plan[r].pos;
          {b.stop_red, b.stop_green, b.stop_blue, b.stop_alpha} = opening_plan[r].rgba;
        end else begin
          b.cmd = CMD_QUERY;
          b.entry_index = opening_plan[r].arg;
        end
        send_beat(b, opening_plan[r].known, opening_plan[r].want);
      end
    end

    phase = 0;
    while (beats_sent < 1900) begin
      case (phase)
        0: cnt = 5'd16;
        1: cnt = 5'd31;
        2: cnt = 5'd17;
        3: cnt = 5'd0;
        4: cnt = 5'd1;
        default: begin
          m = $urandom_range(0, 9);
          if (m == 0) cnt = CFG_W'($urandom_range(17, 31));
          else if (m == 1) cnt = CFG_W'($urandom_range(0, 1));
          else cnt = CFG_W'($urandom_range(2, 16));
        end
      endcase
      set_stop_count(cnt);
      if (beats_sent > 1650) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        m = $urandom_range(0, 2);
        gap_pct = (m == 0) ? 0 : (m == 1) ? 20 : 50;
        m = $urandom_range(0, 2);
        stall_pct = (m == 0) ? 0 : (m == 1) ? 20 : 50;
      end

      n = (cnt > MAX_STOPS) ? MAX_STOPS : int'(cnt);
      style = $urandom_range(0, 5);
      for (int k = 0; k < n; k++) begin
        pos_set[k] = (style == 1) ? 16'($urandom_range(0, 255) * 257) : 16'($urandom);
        if (style == 1 && k > 0 && $urandom_range(0, 2) == 0) pos_set[k] = pos_set[k - 1];
      end
      if (style != 0) begin
        for (int k = 1; k < n; k++) begin
          tmp = pos_set[k];
          m = k;
          while (m > 0 && pos_set[m - 1] > tmp) begin
            pos_set[m] = pos_set[m - 1];
            m--;
          end
          pos_set[m] = tmp;
        end
        if (n > 1 && $urandom_range(0, 1) == 1) begin
          pos_set[0] = 16'h0000;
          pos_set[n - 1] = 16'hFFFF;
        end
      end
      for (int k = 0; k < n; k++) begin
        noise = {$urandom, $urandom};
        b = noise[$bits(in_beat_t)-1:0];
        b.cmd = CMD_LOAD;
        b.stop_slot = k[3:0];
        b.stop_position = pos_set[k];
        send_beat(b, 1'b0, '0);
      end

      nq = $urandom_range(25, 45);
      for (int q = 0; q < nq; q++) begin
        noise = {$urandom, $urandom};
        b = noise[$bits(in_beat_t)-1:0];
        if ($urandom_range(0, 9) == 0) begin
          b.cmd = CMD_LOAD;
        end else begin
          b.cmd = CMD_QUERY;
          if ($urandom_range(0, 7) == 0) b.entry_index = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        send_beat(b, 1'b0, '0);
      end
      phase++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[color_ramp_lut_generator_core] OK");
    end else begin
      $display("[color_ramp_lut_generator_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/crlg_pkg.sv
sv/crlg_ctrl.sv
sv/crlg_dp.sv
sv/color_ramp_lut_generator_core.sv
sv/crlg_chk.sv
tb/tb_color_ramp_lut_generator_core.sv
